@@ rtl/cfec_pkg.sv @@
// Package for the centered FIR with edge clamping: sizes, op codes and the
// command/status structs between controller and datapath. No dependencies.
package cfec_pkg;

  localparam int MAX_TAPS    = 65;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int COEF_FRAC   = 14;
  localparam int ACC_BITS    = 40;
  localparam int HW_MAX      = (MAX_TAPS - 1) / 2;
  localparam int TAP_W       = $clog2(MAX_TAPS);
  localparam int HW_W        = 6;
  localparam int IDX_W       = 7;
  localparam int CNT_W       = 32;
  localparam int PEND_W      = $clog2(HW_MAX + 2);
  localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;

  localparam logic OP_COEF   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic take_coef;
    logic take_sample;
    logic new_block;
    logic tap_clr;
    logic issue;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic pend_gt_hw;
    logic pend_nz;
    logic last;
    logic tap_last;
    logic pipe_busy;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/cfec_ifs.sv @@
// Valid/ready channel interfaces for input and result items.
// Depends on cfec_pkg.
interface cfec_in_if import cfec_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [IDX_W-1:0]              coef_index;
  logic signed [SAMPLE_BITS-1:0] value;
  logic                          last;

  modport source (output valid, op, coef_index, value, last, input ready);
  modport sink   (input valid, op, coef_index, value, last, output ready);
endinterface

interface cfec_out_if import cfec_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          block_end;

  modport source (output valid, filtered, block_end, input ready);
  modport sink   (input valid, filtered, block_end, output ready);
endinterface

@@ rtl/cfec_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cfec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cfec_ctrl.sv @@
// Controller: item acceptance, block tracking and per-output tap sequencing.
// Depends on cfec_pkg.
module cfec_ctrl import cfec_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_op_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TAPS,
    ST_DRAIN
  } state_e;

  state_e state_q;
  logic   in_block_q;
  logic   accept;
  logic   more;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign more       = stat_i.pend_gt_hw || (stat_i.last && stat_i.pend_nz);

  always_comb begin
    cmd_o             = '0;
    cmd_o.take_coef   = accept && (in_op_i == OP_COEF);
    cmd_o.take_sample = accept && (in_op_i == OP_SAMPLE);
    cmd_o.new_block   = !in_block_q;
    cmd_o.tap_clr     = (state_q == ST_CHECK) && more;
    cmd_o.issue       = (state_q == ST_TAPS);
    cmd_o.emit        = (state_q == ST_DRAIN) && !stat_i.pipe_busy && stat_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_block_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.take_sample) begin
            in_block_q <= 1'b1;
            state_q    <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (more) begin
            state_q <= ST_TAPS;
          end else begin
            if (stat_i.last) begin
              in_block_q <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_TAPS: begin
          if (stat_i.tap_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (cmd_o.emit) begin
            state_q <= ST_CHECK;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_taps_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAPS) |-> in_block_q)
    else $error("tap walk outside a block");

endmodule

@@ rtl/cfec_dp.sv @@
// Datapath: coefficient and history RAMs, edge-clamped address generation,
// shared multiply-accumulate, rounding/saturation and the result register.
// Depends on cfec_pkg and cfec_ram.
module cfec_dp import cfec_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [HW_W-1:0]               cfg_wdata_i,
  input  logic [IDX_W-1:0]              in_coef_index_i,
  input  logic signed [SAMPLE_BITS-1:0] in_value_i,
  input  logic                          in_last_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] out_filtered_o,
  output logic                          out_block_end_o,
  input  cmd_t                          cmd_i,
  output stat_t                         stat_o
);

  localparam logic signed [ACC_BITS:0] SAT_HI = (ACC_BITS+1)'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [ACC_BITS:0] SAT_LO = (ACC_BITS+1)'(-(2**(SAMPLE_BITS-1)));
  localparam logic signed [ACC_BITS:0] RND    = (ACC_BITS+1)'(2**(COEF_FRAC-1));

  logic [HW_W-1:0]            hw_q;
  logic [HW_W-1:0]            hw_eff;
  logic [MAX_TAPS-1:0]        coef_vld_q;
  logic [TAP_W-1:0]           wr_pos_q;
  logic [CNT_W-1:0]           sent_q;
  logic [PEND_W-1:0]          pend_q;
  logic                       last_q;
  logic [TAP_W-1:0]           tap_q;
  logic                       s1_vld_q, s1_first_q, s1_cok_q;
  logic                       s2_vld_q, s2_first_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_BITS-1:0] acc_q;
  logic                       out_vld_q;
  logic [SAMPLE_BITS-1:0]     out_data_q;
  logic                       out_end_q;

  logic [TAP_W-1:0]           tap_end;
  logic [PEND_W-1:0]          lag;
  logic [TAP_W:0]             lsum;
  logic                       left;
  logic signed [TAP_W:0]      rsum;
  logic [TAP_W-1:0]           back;
  logic [TAP_W:0]             asum;
  logic [TAP_W-1:0]           hist_raddr;
  logic [TAP_W-1:0]           hist_waddr;
  logic                       coef_we;
  logic [COEF_BITS-1:0]       coef_rdata;
  logic [SAMPLE_BITS-1:0]     hist_rdata;
  logic signed [COEF_BITS-1:0] coef_op;
  logic signed [ACC_BITS:0]   rnd;
  logic signed [ACC_BITS:0]   shr;
  logic signed [ACC_BITS:0]   sat;
  logic                       out_free;

  assign hw_eff  = (hw_q > HW_W'(HW_MAX)) ? HW_W'(HW_MAX) : hw_q;
  assign tap_end = TAP_W'({hw_eff, 1'b0});
  assign lag     = pend_q - PEND_W'(1);

  // left edge: position n+o before the block start replicates the first sample
  assign lsum = (TAP_W+1)'(sent_q[HW_W-1:0]) + (TAP_W+1)'(tap_q);
  assign left = (sent_q[CNT_W-1:HW_W] == '0) && (lsum < (TAP_W+1)'(hw_eff));
  assign rsum = (TAP_W+1)'(lag) + (TAP_W+1)'(hw_eff) - (TAP_W+1)'(tap_q);

  always_comb begin
    if (left) begin
      back = TAP_W'(lag) + TAP_W'(sent_q[HW_W-1:0]);
    end else if (rsum[TAP_W]) begin
      back = '0;
    end else begin
      back = rsum[TAP_W-1:0];
    end
  end

  assign asum = (TAP_W+1)'(wr_pos_q) + (TAP_W+1)'(MAX_TAPS - 1) - (TAP_W+1)'(back);
  assign hist_raddr = (asum >= (TAP_W+1)'(MAX_TAPS)) ?
                      TAP_W'(asum - (TAP_W+1)'(MAX_TAPS)) : asum[TAP_W-1:0];
  assign hist_waddr = cmd_i.new_block ? '0 : wr_pos_q;
  assign coef_we    = cmd_i.take_coef && (in_coef_index_i < IDX_W'(MAX_TAPS));

  cfec_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (TAP_W'(in_coef_index_i)),
    .wdata_i (in_value_i),
    .raddr_i (tap_q),
    .rdata_o (coef_rdata)
  );

  cfec_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.take_sample),
    .waddr_i (hist_waddr),
    .wdata_i (in_value_i),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  assign coef_op = s1_cok_q ? $signed(coef_rdata) : '0;

  assign rnd = (ACC_BITS+1)'(acc_q) + RND;
  assign shr = rnd >>> COEF_FRAC;
  always_comb begin
    if (shr > SAT_HI) begin
      sat = SAT_HI;
    end else if (shr < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = shr;
    end
  end

  assign out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q       <= '0;
      coef_vld_q <= '0;
      wr_pos_q   <= '0;
      sent_q     <= '0;
      pend_q     <= '0;
      last_q     <= 1'b0;
      tap_q      <= '0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hw_q <= cfg_wdata_i;
      end
      if (coef_we) begin
        coef_vld_q[TAP_W'(in_coef_index_i)] <= 1'b1;
      end
      if (cmd_i.take_sample) begin
        last_q <= in_last_i;
        if (cmd_i.new_block) begin
          wr_pos_q <= TAP_W'(1);
          sent_q   <= '0;
          pend_q   <= PEND_W'(1);
        end else begin
          wr_pos_q <= (wr_pos_q == TAP_W'(MAX_TAPS - 1)) ? '0 : wr_pos_q + TAP_W'(1);
          pend_q   <= pend_q + PEND_W'(1);
        end
      end else if (cmd_i.emit) begin
        sent_q <= sent_q + CNT_W'(1);
        pend_q <= pend_q - PEND_W'(1);
      end
      if (cmd_i.tap_clr) begin
        tap_q <= '0;
      end else if (cmd_i.issue) begin
        tap_q <= tap_q + TAP_W'(1);
      end
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= (tap_q == '0);
    s1_cok_q   <= coef_vld_q[tap_q];
    s2_first_q <= s1_first_q;
    prod_q     <= $signed(hist_rdata) * coef_op;
    if (s2_vld_q) begin
      acc_q <= (s2_first_q ? '0 : acc_q) + ACC_BITS'(prod_q);
    end
    if (cmd_i.emit) begin
      out_data_q <= sat[SAMPLE_BITS-1:0];
      out_end_q  <= last_q && (pend_q == PEND_W'(1));
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_filtered_o  = out_data_q;
  assign out_block_end_o = out_end_q;

  assign stat_o.pend_gt_hw = pend_q > PEND_W'(hw_eff);
  assign stat_o.pend_nz    = pend_q != '0;
  assign stat_o.last       = last_q;
  assign stat_o.tap_last   = tap_q == tap_end;
  assign stat_o.pipe_busy  = s1_vld_q || s2_vld_q;
  assign stat_o.out_free   = out_free;

  a_emit_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (pend_q != '0) && !s1_vld_q && !s2_vld_q)
    else $error("result emitted without a finished pending output");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PEND_W'(HW_MAX + 1))
    else $error("pending outputs exceed the window");

  a_wr_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pos_q <= TAP_W'(MAX_TAPS - 1))
    else $error("history write position out of range");

endmodule

@@ rtl/centered_fir_edge_clamp_top.sv @@
// Each result that a sample item releases is built by one shared multiply-accumulate
// that walks the taps, followed by a pipeline drain. No new item is accepted until
// all results released by the previous sample item have been emitted. A sample item
// releases up to 33 results (half_width 32, flush at the end of a block).
// Reset is asynchronous, active low; coefficients read as zero until written.
// Top level of the centered FIR with edge clamping. Depends on cfec_pkg,
// cfec_ifs, cfec_ctrl and cfec_dp.
module centered_fir_edge_clamp_top import cfec_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [HW_W-1:0] cfg_wdata_i,
  cfec_in_if.sink         in_i,
  cfec_out_if.source      out_o
);

  cmd_t  cmd;
  stat_t stat;

  cfec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cfec_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_coef_index_i (in_i.coef_index),
    .in_value_i      (in_i.value),
    .in_last_i       (in_i.last),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_filtered_o  (out_o.filtered),
    .out_block_end_o (out_o.block_end),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule
